/* rtl/sltb_pkg.sv */
package sltb_pkg;

   // Operation codes carried by req_op.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOCATE = 2'd1,
      OP_READ   = 2'd2,
      OP_SPLIT  = 2'd3
   } op_type;

   // Status codes carried by rsp_status.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // Fixed field widths of the request and response words.
   localparam int KEY_W   = 32;
   localparam int RID_W   = 32;
   localparam int INDEX_W = 5;
   localparam int OUTIX_W = 6;
   localparam int LIMIT_W = 5;

   // Reset value of the capacity limit register.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd31;

endpackage

/* rtl/sltb_ram.sv */
module sltb_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/sorted_leaf_key_table.sv */
// Sorted leaf key table: one B+ tree leaf of (key, record id) pairs in one RAM.
// Insert shifts larger keys up from the top, then places the new pair; locate scans up
// from entry 0; insert-and-split then streams the back half one word per cycle.
// One request at a time; busy is high until the last word is issued.
// The insert cost is set by the shift walk through the single read/write RAM port pair.
// Reset (synchronous, active high) empties the table and sets the limit to 31.
module sorted_leaf_key_table #(
   parameter int MAX_KEYS = 31,
   parameter int RID_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic signed [sltb_pkg::KEY_W-1:0] req_key,
   input  logic [sltb_pkg::RID_W-1:0]    req_record_id,
   input  logic [sltb_pkg::INDEX_W-1:0]  req_index,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [sltb_pkg::OUTIX_W-1:0]  rsp_out_index,
   output logic signed [sltb_pkg::KEY_W-1:0] rsp_out_key,
   output logic [sltb_pkg::RID_W-1:0]    rsp_out_record_id,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  logic [sltb_pkg::LIMIT_W-1:0]  csr_write_data
);

   import sltb_pkg::*;

   localparam int DEPTH = MAX_KEYS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LW    = (CW > OUTIX_W) ? CW : OUTIX_W;
   localparam int DW    = KEY_W + RID_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SCAN,
      S_INS_PLACE,
      S_LOC_SCAN,
      S_RD_WAIT,
      S_SPL_START,
      S_SPL_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic                  split_ff, split_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [RID_BITS-1:0]   rid_ff, rid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [OUTIX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [RID_W-1:0]      rsp_rid_ff, rsp_rid_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DW-1:0]         rd_data;

   logic signed [KEY_W-1:0] rd_key;
   logic [RID_BITS-1:0]   rd_rid;
   logic [63:0]           req_rid_ext;
   logic [63:0]           rd_rid_ext;
   logic [LW-1:0]         lim_w;
   logic                  full;
   logic [AW-1:0]         front;

   // Entry table: key in the upper bits, record id in the lower bits.
   sltb_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH),
      .ADDR_W(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Field views and the record id fitted to the stored width.
   assign rd_key      = rd_data[DW-1 -: KEY_W];
   assign rd_rid      = rd_data[RID_BITS-1:0];
   assign req_rid_ext = {32'd0, req_record_id};
   assign rd_rid_ext  = 64'(rd_rid);

   // The node is full once the count passes the usable limit.
   assign lim_w = (LW'(limit_ff) < LW'(MAX_KEYS)) ? LW'(limit_ff) : LW'(MAX_KEYS);
   assign full  = LW'(count_ff) > lim_w;
   assign front = AW'(count_ff >> 1);

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_index     = rsp_index_ff;
   assign rsp_out_key       = rsp_key_ff;
   assign rsp_out_record_id = rsp_rid_ff;
   assign rsp_last          = rsp_last_ff;

   // Sequencer: walks the table through the RAM one entry per cycle.
   always_comb begin
      logic ins_done;
      ins_done      = 1'b0;
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      limit_in      = csr_write_en ? csr_write_data : limit_ff;
      split_in      = split_ff;
      key_in        = key_ff;
      rid_in        = rid_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_rid_in    = rsp_rid_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = {key_ff, rid_ff};
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in   = req_key;
               rid_in   = req_rid_ext[RID_BITS-1:0];
               split_in = (op_type'(req_op) == OP_SPLIT);
               unique case (op_type'(req_op)) inside
                  OP_INSERT, OP_SPLIT: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_index_in  = '0;
                        rsp_key_in    = '0;
                        rsp_rid_in    = '0;
                        rsp_last_in   = 1'b1;
                     end else if (count_ff == '0) begin
                        ptr_in   = '0;
                        state_in = S_INS_PLACE;
                     end else begin
                        // Start the shift walk from the top entry.
                        ptr_in   = AW'(count_ff);
                        rd_en    = 1'b1;
                        rd_addr  = AW'(count_ff - CW'(1));
                        state_in = S_INS_SCAN;
                     end
                  end
                  OP_LOCATE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_MISSING;
                        rsp_index_in  = '0;
                        rsp_key_in    = '0;
                        rsp_rid_in    = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ptr_in   = '0;
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_LOC_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (LW'(req_index) < LW'(count_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_index);
                        state_in = S_RD_WAIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_MISSING;
                        rsp_key_in    = '0;
                        rsp_rid_in    = '0;
                        rsp_last_in   = 1'b1;
                     end
                     rsp_index_in = OUTIX_W'(req_index);
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_INS_SCAN: begin
            // rd_data holds the entry just below the gap at ptr.
            if (rd_key > key_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_data;
               ptr_in  = ptr_ff - AW'(1);
               if (ptr_ff != AW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - AW'(2);
               end else begin
                  state_in = S_INS_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               ins_done = 1'b1;
            end
         end

         S_INS_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            ins_done = 1'b1;
         end

         S_LOC_SCAN: begin
            if (rd_key == key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_index_in  = OUTIX_W'(ptr_ff);
               rsp_key_in    = '0;
               rsp_rid_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (rd_key > key_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISSING;
               rsp_index_in  = OUTIX_W'(ptr_ff);
               rsp_key_in    = '0;
               rsp_rid_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (CW'(ptr_ff) + CW'(1) == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISSING;
               rsp_index_in  = OUTIX_W'(count_ff);
               rsp_key_in    = '0;
               rsp_rid_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ptr_in  = ptr_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(1);
            end
         end

         S_RD_WAIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_key_in    = rd_key;
            rsp_rid_in    = rd_rid_ext[RID_W-1:0];
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         S_SPL_START: begin
            // The count already includes the new pair; the back half starts at front.
            ptr_in   = front;
            rd_en    = 1'b1;
            rd_addr  = front;
            state_in = S_SPL_EMIT;
         end

         S_SPL_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_index_in  = OUTIX_W'(ptr_ff - front);
            rsp_key_in    = rd_key;
            rsp_rid_in    = rd_rid_ext[RID_W-1:0];
            if (CW'(ptr_ff) == count_ff - CW'(1)) begin
               rsp_last_in = 1'b1;
               count_in    = count_ff >> 1;
               state_in    = S_IDLE;
            end else begin
               rsp_last_in = 1'b0;
               ptr_in      = ptr_ff + AW'(1);
               rd_en       = 1'b1;
               rd_addr     = ptr_ff + AW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The new pair is in place: count it and report or start the split run.
      if (ins_done) begin
         count_in = count_ff + CW'(1);
         if (split_ff) begin
            state_in = S_SPL_START;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_index_in  = OUTIX_W'(ptr_ff);
            rsp_key_in    = '0;
            rsp_rid_in    = '0;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
      end
   end

   // State, control and the response word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      split_ff      <= split_in;
      key_ff        <= key_in;
      rid_ff        <= rid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_rid_ff    <= rsp_rid_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

/* rtl/sltb_checker.sv */
module sltb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [1:0]                    rsp_status,
   input logic [sltb_pkg::OUTIX_W-1:0]  rsp_out_index,
   input logic signed [sltb_pkg::KEY_W-1:0] rsp_out_key,
   input logic                          rsp_last
);

   import sltb_pkg::*;

   // A split run streams without gaps.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("split run has a gap");

   // Positions within a split run count up by one per word.
   a_run_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_out_index == $past(rsp_out_index) + 6'd1)
      else $error("split run position did not advance by one");

   // The block stays busy while a run is still being sent.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("block went idle in the middle of a split run");

   // Only split runs give more than one word, and those carry ok status.
   a_run_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK)
      else $error("non-final word without ok status");

   // A full node answers with a single cleared word.
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_last && rsp_out_index == '0 && rsp_out_key == '0)
      else $error("full response is not a single cleared word");

endmodule

bind sorted_leaf_key_table sltb_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_out_index(rsp_out_index),
   .rsp_out_key  (rsp_out_key),
   .rsp_last     (rsp_last)
);
